>>> sv/watm_pkg.sv
// Shared types, field widths and codes for the weekday alarm table matcher.
// Used by the controller, the datapath and the top level; depends on nothing.
package watm_pkg;

   localparam int ALARM_SLOTS_DEF  = 16;
   localparam int FIRE_CAP         = 16;
   localparam int MINUTES_PER_HOUR = 60;

   localparam int OP_W       = 3;
   localparam int ID_W       = 16;
   localparam int HOUR_W     = 5;
   localparam int MIN_W      = 6;
   localparam int DAYS_W     = 7;
   localparam int DOW_W      = 3;
   localparam int STATUS_W   = 2;
   localparam int MOD_W      = 11;
   localparam int FIRE_CNT_W = $clog2(FIRE_CAP + 1);

   localparam logic [OP_W-1:0] OP_TICK   = 3'd0;
   localparam logic [OP_W-1:0] OP_ADD    = 3'd1;
   localparam logic [OP_W-1:0] OP_REMOVE = 3'd2;
   localparam logic [OP_W-1:0] OP_UPDATE = 3'd3;
   localparam logic [OP_W-1:0] OP_ENABLE = 3'd4;

   localparam logic [STATUS_W-1:0] STATUS_OK        = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_NOT_FOUND = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_FULL      = 2'd2;

   localparam logic KIND_DONE  = 1'b0;
   localparam logic KIND_FIRED = 1'b1;

   typedef struct packed {
      logic [ID_W-1:0]   ident;
      logic [HOUR_W-1:0] hour;
      logic [MIN_W-1:0]  minute;
      logic [DAYS_W-1:0] days;
      logic              enabled;
   } entry_type;

   localparam int ENTRY_W = $bits(entry_type);

   typedef struct packed {
      logic load_req;
      logic idx_clr;
      logic idx_inc;
      logic rd_en;
      logic rd_next;
      logic tick_prep;
      logic fire;
      logic flush;
      logic add_do;
      logic modify_do;
      logic shift_wr;
      logic remove_fired;
      logic remove_fin;
      logic push_resp;
      logic resp_miss;
   } cmd_type;

   typedef struct packed {
      logic idx_end;
      logic idx_last;
      logic hit;
      logic fire_match;
      logic pend_valid;
      logic out_free;
   } stat_type;

endpackage

>>> sv/watm_ram.sv
// Generic single-write, single-read RAM with a registered read port.
// Holds the alarm entries; depends on nothing.
module watm_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                                      clock,
   input  logic                                      wr_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                          wr_data,
   input  logic                                      rd_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                          rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

>>> sv/watm_ctrl.sv
// Controller state machine that sequences ticks, adds, lookups and removals.
// Depends on watm_pkg; drives the datapath by command and reads its status.
module watm_ctrl
   import watm_pkg::*;
(
   input  logic            clock,
   input  logic            reset,
   input  logic            req_valid,
   input  logic [OP_W-1:0] req_op,
   output logic            req_stall,
   input  stat_type        stat,
   output cmd_type         cmd
);

   typedef enum logic [12:0] {
      S_IDLE      = 13'h0001,
      S_TICK_PREP = 13'h0002,
      S_TICK_RD   = 13'h0004,
      S_TICK_CHK  = 13'h0008,
      S_TICK_END  = 13'h0010,
      S_ADD       = 13'h0020,
      S_SCAN_RD   = 13'h0040,
      S_SCAN_CHK  = 13'h0080,
      S_MODIFY    = 13'h0100,
      S_SH_RD     = 13'h0200,
      S_SH_WR     = 13'h0400,
      S_RESP_OK   = 13'h0800,
      S_RESP_MISS = 13'h1000
   } state_type;

   state_type       state_ff, state_in;
   logic [OP_W-1:0] op_ff, op_in;

   always_comb begin
      state_in = state_ff;
      op_in    = op_ff;
      cmd      = '0;
      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.load_req = 1'b1;
               cmd.idx_clr  = 1'b1;
               op_in        = req_op;
               case (req_op) inside
                  OP_TICK:                         state_in = S_TICK_PREP;
                  OP_ADD:                          state_in = S_ADD;
                  OP_REMOVE, OP_UPDATE, OP_ENABLE: state_in = S_SCAN_RD;
                  default:                         state_in = S_IDLE;
               endcase
            end
         end
         S_TICK_PREP: begin
            cmd.tick_prep = 1'b1;
            state_in      = S_TICK_RD;
         end
         S_TICK_RD: begin
            if (stat.idx_end) begin
               state_in = S_TICK_END;
            end else begin
               cmd.rd_en = 1'b1;
               state_in  = S_TICK_CHK;
            end
         end
         S_TICK_CHK: begin
            if (!stat.fire_match) begin
               cmd.idx_inc = 1'b1;
               state_in    = S_TICK_RD;
            end else if (!stat.pend_valid || stat.out_free) begin
               cmd.fire    = 1'b1;
               cmd.idx_inc = 1'b1;
               state_in    = S_TICK_RD;
            end
         end
         S_TICK_END: begin
            if (!stat.pend_valid) begin
               state_in = S_IDLE;
            end else if (stat.out_free) begin
               cmd.flush = 1'b1;
               state_in  = S_IDLE;
            end
         end
         S_ADD: begin
            if (stat.out_free) begin
               cmd.add_do = 1'b1;
               state_in   = S_IDLE;
            end
         end
         S_SCAN_RD: begin
            if (stat.idx_end) begin
               state_in = S_RESP_MISS;
            end else begin
               cmd.rd_en = 1'b1;
               state_in  = S_SCAN_CHK;
            end
         end
         S_SCAN_CHK: begin
            if (!stat.hit) begin
               cmd.idx_inc = 1'b1;
               state_in    = S_SCAN_RD;
            end else if (op_ff == OP_REMOVE) begin
               cmd.remove_fired = 1'b1;
               state_in         = S_SH_RD;
            end else begin
               state_in = S_MODIFY;
            end
         end
         S_MODIFY: begin
            cmd.modify_do = 1'b1;
            state_in      = S_RESP_OK;
         end
         S_SH_RD: begin
            if (stat.idx_last) begin
               cmd.remove_fin = 1'b1;
               state_in       = S_RESP_OK;
            end else begin
               cmd.rd_en   = 1'b1;
               cmd.rd_next = 1'b1;
               state_in    = S_SH_WR;
            end
         end
         S_SH_WR: begin
            cmd.shift_wr = 1'b1;
            cmd.idx_inc  = 1'b1;
            state_in     = S_SH_RD;
         end
         S_RESP_OK: begin
            if (stat.out_free) begin
               cmd.push_resp = 1'b1;
               state_in      = S_IDLE;
            end
         end
         S_RESP_MISS: begin
            if (stat.out_free) begin
               cmd.push_resp = 1'b1;
               cmd.resp_miss = 1'b1;
               state_in      = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
      op_ff <= op_in;
   end

   assign req_stall = (state_ff != S_IDLE);

endmodule

>>> sv/watm_dp.sv
// Datapath: request word, alarm entry RAM, fired marks, counters and result word.
// Depends on watm_pkg and watm_ram; acts on commands from watm_ctrl.
module watm_dp
   import watm_pkg::*;
#(
   parameter int ALARM_SLOTS = ALARM_SLOTS_DEF
) (
   input  logic                clock,
   input  logic                reset,
   input  logic [ID_W-1:0]     req_alarm_id,
   input  logic [HOUR_W-1:0]   req_hour,
   input  logic [MIN_W-1:0]    req_minute,
   input  logic [DAYS_W-1:0]   req_day_mask,
   input  logic                req_enable,
   input  logic [DOW_W-1:0]    req_day_of_week,
   input  logic [OP_W-1:0]     req_op,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output logic                rsp_kind,
   output logic [ID_W-1:0]     rsp_result_id,
   output logic [STATUS_W-1:0] rsp_status,
   output logic                rsp_last,
   input  cmd_type             cmd,
   output stat_type            stat
);

   localparam int IDX_W = (ALARM_SLOTS > 1) ? $clog2(ALARM_SLOTS) : 1;
   localparam int CNT_W = $clog2(ALARM_SLOTS + 1);
   localparam logic [CNT_W-1:0] SLOTS_C = CNT_W'(ALARM_SLOTS);

   logic [OP_W-1:0]        op_ff, op_in;
   logic [ID_W-1:0]        id_ff, id_in;
   logic [HOUR_W-1:0]      hour_ff, hour_in;
   logic [MIN_W-1:0]       minute_ff, minute_in;
   logic [DAYS_W-1:0]      days_ff, days_in;
   logic                   en_ff, en_in;
   logic [DOW_W-1:0]       dow_ff, dow_in;

   logic [CNT_W-1:0]       count_ff, count_in;
   logic [CNT_W-1:0]       idx_ff, idx_in;
   logic [ALARM_SLOTS-1:0] fired_ff, fired_in;
   logic [ID_W-1:0]        next_id_ff, next_id_in;
   logic [MOD_W-1:0]       prev_mod_ff, prev_mod_in;
   logic [FIRE_CNT_W-1:0]  fire_cnt_ff, fire_cnt_in;
   logic                   pend_valid_ff, pend_valid_in;
   logic [ID_W-1:0]        pend_id_ff, pend_id_in;

   logic                   rsp_valid_ff, rsp_valid_in;
   logic                   rsp_kind_ff, rsp_kind_in;
   logic [ID_W-1:0]        rsp_id_ff, rsp_id_in;
   logic [STATUS_W-1:0]    rsp_status_ff, rsp_status_in;
   logic                   rsp_last_ff, rsp_last_in;

   entry_type              rd_entry;
   entry_type              wr_entry;
   logic                   wr_en;
   logic [IDX_W-1:0]       wr_addr;
   logic [IDX_W-1:0]       rd_addr;
   logic [CNT_W-1:0]       idx_plus;
   logic [MOD_W-1:0]       tick_mod;
   logic                   table_full;
   logic                   out_free;
   logic                   day_ok;
   logic [DAYS_W:0]        days_ext;
   logic                   push_any;
   logic [ALARM_SLOTS-1:0] valid_mask;

   assign idx_plus   = idx_ff + CNT_W'(1);
   assign table_full = (count_ff == SLOTS_C);
   assign out_free   = !rsp_valid_ff || !rsp_stall;
   assign tick_mod   = MOD_W'(hour_ff) * MOD_W'(MINUTES_PER_HOUR) + MOD_W'(minute_ff);
   assign days_ext   = {1'b0, rd_entry.days};
   assign day_ok     = (rd_entry.days == '0) || days_ext[dow_ff];
   assign rd_addr    = cmd.rd_next ? idx_plus[IDX_W-1:0] : idx_ff[IDX_W-1:0];

   always_comb begin
      for (int i = 0; i < ALARM_SLOTS; i++) begin
         valid_mask[i] = (CNT_W'(i) < count_ff);
      end
   end

   assign stat.idx_end    = (idx_ff == count_ff);
   assign stat.idx_last   = (idx_plus == count_ff);
   assign stat.hit        = (rd_entry.ident == id_ff);
   assign stat.fire_match = rd_entry.enabled && !fired_ff[idx_ff[IDX_W-1:0]]
                            && (rd_entry.hour == hour_ff) && (rd_entry.minute == minute_ff)
                            && day_ok && (fire_cnt_ff != FIRE_CNT_W'(FIRE_CAP));
   assign stat.pend_valid = pend_valid_ff;
   assign stat.out_free   = out_free;

   always_comb begin
      wr_en    = 1'b0;
      wr_addr  = idx_ff[IDX_W-1:0];
      wr_entry = rd_entry;
      if (cmd.add_do && !table_full) begin
         wr_en          = 1'b1;
         wr_addr        = count_ff[IDX_W-1:0];
         wr_entry.ident = next_id_ff;
         wr_entry.hour   = hour_ff;
         wr_entry.minute = minute_ff;
         wr_entry.days   = days_ff;
         wr_entry.enabled = en_ff;
      end else if (cmd.modify_do) begin
         wr_en            = 1'b1;
         wr_entry.enabled = en_ff;
         if (op_ff == OP_UPDATE) begin
            wr_entry.hour   = hour_ff;
            wr_entry.minute = minute_ff;
            wr_entry.days   = days_ff;
         end
      end else if (cmd.shift_wr) begin
         wr_en = 1'b1;
      end
   end

   watm_ram #(
      .WIDTH (ENTRY_W),
      .DEPTH (ALARM_SLOTS)
   ) u_entry_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_entry),
      .rd_en   (cmd.rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_entry)
   );

   always_comb begin
      op_in         = op_ff;
      id_in         = id_ff;
      hour_in       = hour_ff;
      minute_in     = minute_ff;
      days_in       = days_ff;
      en_in         = en_ff;
      dow_in        = dow_ff;
      count_in      = count_ff;
      idx_in        = idx_ff;
      fired_in      = fired_ff;
      next_id_in    = next_id_ff;
      prev_mod_in   = prev_mod_ff;
      fire_cnt_in   = fire_cnt_ff;
      pend_valid_in = pend_valid_ff;
      pend_id_in    = pend_id_ff;
      rsp_valid_in  = rsp_valid_ff && rsp_stall;
      rsp_kind_in   = rsp_kind_ff;
      rsp_id_in     = rsp_id_ff;
      rsp_status_in = rsp_status_ff;
      rsp_last_in   = rsp_last_ff;
      push_any      = 1'b0;

      if (cmd.load_req) begin
         op_in     = req_op;
         id_in     = req_alarm_id;
         hour_in   = req_hour;
         minute_in = req_minute;
         days_in   = req_day_mask;
         en_in     = req_enable;
         dow_in    = req_day_of_week;
      end
      if (cmd.idx_clr) begin
         idx_in = '0;
      end
      if (cmd.idx_inc) begin
         idx_in = idx_plus;
      end

      if (cmd.tick_prep) begin
         if (tick_mod < prev_mod_ff) begin
            fired_in = '0;
         end
         prev_mod_in   = tick_mod;
         fire_cnt_in   = '0;
         pend_valid_in = 1'b0;
      end

      if (cmd.fire) begin
         if (pend_valid_ff) begin
            push_any      = 1'b1;
            rsp_kind_in   = KIND_FIRED;
            rsp_id_in     = pend_id_ff;
            rsp_status_in = STATUS_OK;
            rsp_last_in   = 1'b0;
         end
         pend_valid_in                    = 1'b1;
         pend_id_in                       = rd_entry.ident;
         fired_in[idx_ff[IDX_W-1:0]]      = 1'b1;
         fire_cnt_in                      = fire_cnt_ff + FIRE_CNT_W'(1);
      end

      if (cmd.flush) begin
         push_any      = 1'b1;
         rsp_kind_in   = KIND_FIRED;
         rsp_id_in     = pend_id_ff;
         rsp_status_in = STATUS_OK;
         rsp_last_in   = 1'b1;
         pend_valid_in = 1'b0;
      end

      if (cmd.add_do) begin
         push_any    = 1'b1;
         rsp_kind_in = KIND_DONE;
         rsp_last_in = 1'b1;
         if (table_full) begin
            rsp_id_in     = '0;
            rsp_status_in = STATUS_FULL;
         end else begin
            rsp_id_in                         = next_id_ff;
            rsp_status_in                     = STATUS_OK;
            fired_in[count_ff[IDX_W-1:0]]     = 1'b0;
            count_in                          = count_ff + CNT_W'(1);
            next_id_in                        = next_id_ff + ID_W'(1);
         end
      end

      if (cmd.modify_do && (op_ff == OP_UPDATE)) begin
         fired_in[idx_ff[IDX_W-1:0]] = 1'b0;
      end

      if (cmd.remove_fired) begin
         for (int i = 0; i < ALARM_SLOTS; i++) begin
            if (CNT_W'(i) >= idx_ff) begin
               fired_in[i] = (i + 1 < ALARM_SLOTS) ? fired_ff[(i + 1) % ALARM_SLOTS] : 1'b0;
            end
         end
      end

      if (cmd.remove_fin) begin
         count_in = count_ff - CNT_W'(1);
      end

      if (cmd.push_resp) begin
         push_any      = 1'b1;
         rsp_kind_in   = KIND_DONE;
         rsp_id_in     = id_ff;
         rsp_status_in = cmd.resp_miss ? STATUS_NOT_FOUND : STATUS_OK;
         rsp_last_in   = 1'b1;
      end

      if (push_any) begin
         rsp_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff      <= '0;
         idx_ff        <= '0;
         fired_ff      <= '0;
         next_id_ff    <= ID_W'(1);
         prev_mod_ff   <= '0;
         fire_cnt_ff   <= '0;
         pend_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         count_ff      <= count_in;
         idx_ff        <= idx_in;
         fired_ff      <= fired_in;
         next_id_ff    <= next_id_in;
         prev_mod_ff   <= prev_mod_in;
         fire_cnt_ff   <= fire_cnt_in;
         pend_valid_ff <= pend_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
      op_ff         <= op_in;
      id_ff         <= id_in;
      hour_ff       <= hour_in;
      minute_ff     <= minute_in;
      days_ff       <= days_in;
      en_ff         <= en_in;
      dow_ff        <= dow_in;
      pend_id_ff    <= pend_id_in;
      rsp_kind_ff   <= rsp_kind_in;
      rsp_id_ff     <= rsp_id_in;
      rsp_status_ff <= rsp_status_in;
      rsp_last_ff   <= rsp_last_in;
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_kind      = rsp_kind_ff;
   assign rsp_result_id = rsp_id_ff;
   assign rsp_status    = rsp_status_ff;
   assign rsp_last      = rsp_last_ff;

   count_bound_a : assert property (@(posedge clock) disable iff (reset)
      count_ff <= SLOTS_C)
      else $error("Alarm count exceeds the table size.");

   fired_in_table_a : assert property (@(posedge clock) disable iff (reset)
      (fired_ff & ~valid_mask) == '0)
      else $error("A fired mark is set outside the valid entries.");

   no_overwrite_a : assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_stall) |-> !push_any)
      else $error("A result word was pushed over a stalled one.");

   add_count_a : assert property (@(posedge clock) disable iff (reset)
      (cmd.add_do && !table_full) |=> (count_ff == $past(count_ff) + CNT_W'(1)))
      else $error("A successful add did not grow the table.");

endmodule

>>> sv/weekday_alarm_table_matcher_unit.sv
// Top level of the weekday alarm table matcher: controller plus datapath.
// Depends on watm_pkg, watm_ctrl, watm_dp and watm_ram.
//
// The req channel carries one request word: tick, add, remove, update or
// set enable, with its alarm fields. The rsp channel returns result words:
// one word for each add, remove, update and set enable, and one word for
// each alarm that fires on a tick, the final word of a request carrying
// rsp_last. A tick with no firing alarm and an unknown op return nothing.
// The block takes one request at a time and holds req_stall high until the
// request's last word has been loaded into the output register.
// Entries live in a RAM with a registered read, so each visited entry is
// read in one state and checked in the next; a remove then moves each later
// entry down one slot with a read state and a write state. An add is handled
// in its own state, and each result word is registered.
// When rsp_stall is high the result word holds and the walk pauses at the
// next word it must emit. Reset empties the table, clears all fired marks,
// sets the next id to one and the stored minute of day to zero.
module weekday_alarm_table_matcher_unit
   import watm_pkg::*;
#(
   parameter int ALARM_SLOTS = ALARM_SLOTS_DEF
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_stall,
   input  logic [OP_W-1:0]     req_op,
   input  logic [ID_W-1:0]     req_alarm_id,
   input  logic [HOUR_W-1:0]   req_hour,
   input  logic [MIN_W-1:0]    req_minute,
   input  logic [DAYS_W-1:0]   req_day_mask,
   input  logic                req_enable,
   input  logic [DOW_W-1:0]    req_day_of_week,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output logic                rsp_kind,
   output logic [ID_W-1:0]     rsp_result_id,
   output logic [STATUS_W-1:0] rsp_status,
   output logic                rsp_last
);

   cmd_type  cmd;
   stat_type stat;

   watm_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_op    (req_op),
      .req_stall (req_stall),
      .stat      (stat),
      .cmd       (cmd)
   );

   watm_dp #(
      .ALARM_SLOTS (ALARM_SLOTS)
   ) u_dp (
      .clock           (clock),
      .reset           (reset),
      .req_alarm_id    (req_alarm_id),
      .req_hour        (req_hour),
      .req_minute      (req_minute),
      .req_day_mask    (req_day_mask),
      .req_enable      (req_enable),
      .req_day_of_week (req_day_of_week),
      .req_op          (req_op),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_kind        (rsp_kind),
      .rsp_result_id   (rsp_result_id),
      .rsp_status      (rsp_status),
      .rsp_last        (rsp_last),
      .cmd             (cmd),
      .stat            (stat)
   );

endmodule

>>> test/weekday_alarm_table_matcher_unit_tb.sv
// Self-checking testbench for weekday_alarm_table_matcher_unit: it predicts every result word
// from its own copy of the alarm table and checks each word as it leaves the block.
// Depends on watm_pkg and the RTL of the block.
`timescale 1ns / 1ps

module weekday_alarm_table_matcher_unit_tb;
   import watm_pkg::*;

   localparam int SLOTS = ALARM_SLOTS_DEF;
   localparam longint CYCLE_LIMIT = 2_000_000;
   localparam int DRAIN_LIMIT = 20_000;
   localparam int SETTLE_CYCLES = 100;
   localparam int RANDOM_ITEMS = 500;
   localparam logic [OP_W-1:0] OP_RESERVED = 3'd5;
   localparam logic [OP_W-1:0] OP_TOP = {OP_W{1'b1}};
   localparam int DOW_TOP = (1 << DOW_W) - 1;

   typedef struct packed {
      logic [OP_W-1:0]   op;
      logic [ID_W-1:0]   alarm_id;
      logic [HOUR_W-1:0] hour;
      logic [MIN_W-1:0]  minute;
      logic [DAYS_W-1:0] day_mask;
      logic              enable;
      logic [DOW_W-1:0]  day_of_week;
   } alarm_request_type;

   typedef struct packed {
      logic                kind;
      logic [ID_W-1:0]     result_id;
      logic [STATUS_W-1:0] status;
      logic                last;
   } alarm_result_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_stall;
   logic [OP_W-1:0] req_op = '0;
   logic [ID_W-1:0] req_alarm_id = '0;
   logic [HOUR_W-1:0] req_hour = '0;
   logic [MIN_W-1:0] req_minute = '0;
   logic [DAYS_W-1:0] req_day_mask = '0;
   logic req_enable = 1'b0;
   logic [DOW_W-1:0] req_day_of_week = '0;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   logic rsp_kind;
   logic [ID_W-1:0] rsp_result_id;
   logic [STATUS_W-1:0] rsp_status;
   logic rsp_last;

   // Expected alarm table, kept in step with every accepted request.
   logic              alarm_valid   [SLOTS];
   logic [ID_W-1:0]   alarm_ident   [SLOTS];
   logic [HOUR_W-1:0] alarm_hour    [SLOTS];
   logic [MIN_W-1:0]  alarm_minute  [SLOTS];
   logic [DAYS_W-1:0] alarm_days    [SLOTS];
   logic              alarm_enabled [SLOTS];
   logic              alarm_fired   [SLOTS];
   logic [ID_W-1:0]   next_alarm_id;
   logic [MOD_W-1:0]  last_minute_of_day;

   alarm_result_type expected_words[$];

   int unsigned sender_idle_max = 0;
   int unsigned receiver_idle_max = 0;
   int unsigned rsp_hold_left = 0;
   int unsigned rsp_gap_left = 0;
   longint cycle_count = 0;
   int mismatch_count = 0;
   int requests_sent = 0;
   int words_checked = 0;
   int fired_words = 0;
   int full_replies = 0;
   int missing_replies = 0;

   weekday_alarm_table_matcher_unit dut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_op(req_op),
      .req_alarm_id(req_alarm_id),
      .req_hour(req_hour),
      .req_minute(req_minute),
      .req_day_mask(req_day_mask),
      .req_enable(req_enable),
      .req_day_of_week(req_day_of_week),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_kind(rsp_kind),
      .rsp_result_id(rsp_result_id),
      .rsp_status(rsp_status),
      .rsp_last(rsp_last)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("FAIL");
         $finish;
      end
   end

   function automatic alarm_result_type done_word(logic [ID_W-1:0] ident,
                                                  logic [STATUS_W-1:0] status);
      alarm_result_type w;
      w.kind = KIND_DONE;
      w.result_id = ident;
      w.status = status;
      w.last = 1'b1;
      return w;
   endfunction

   function automatic void clear_alarm_table();
      for (int i = 0; i < SLOTS; i++) begin
         alarm_valid[i] = 1'b0;
         alarm_ident[i] = '0;
         alarm_hour[i] = '0;
         alarm_minute[i] = '0;
         alarm_days[i] = '0;
         alarm_enabled[i] = 1'b0;
         alarm_fired[i] = 1'b0;
      end
      next_alarm_id = ID_W'(1);
      last_minute_of_day = '0;
   endfunction

   function automatic int table_count();
      int n;
      n = 0;
      for (int i = 0; i < SLOTS; i++)
         if (alarm_valid[i])
            n++;
      return n;
   endfunction

   function automatic void predict_alarm_words(alarm_request_type r);
      alarm_result_type fired[$];
      alarm_result_type w;
      int slot;
      int day_minute;
      slot = -1;
      if (r.op == OP_TICK) begin
         day_minute = int'(r.hour) * MINUTES_PER_HOUR + int'(r.minute);
         if (day_minute < int'(last_minute_of_day))
            for (int i = 0; i < SLOTS; i++)
               alarm_fired[i] = 1'b0;
         last_minute_of_day = day_minute[MOD_W-1:0];
         for (int i = 0; i < SLOTS && fired.size() < FIRE_CAP; i++) begin
            if (alarm_valid[i] && alarm_enabled[i] && !alarm_fired[i]
                && alarm_hour[i] == r.hour && alarm_minute[i] == r.minute
                && (alarm_days[i] == '0
                    || (r.day_of_week < DAYS_W && alarm_days[i][r.day_of_week]))) begin
               alarm_fired[i] = 1'b1;
               w.kind = KIND_FIRED;
               w.result_id = alarm_ident[i];
               w.status = STATUS_OK;
               w.last = 1'b0;
               fired.push_back(w);
            end
         end
         if (fired.size() > 0)
            fired[fired.size() - 1].last = 1'b1;
         foreach (fired[k])
            expected_words.push_back(fired[k]);
      end else if (r.op == OP_ADD) begin
         for (int i = SLOTS - 1; i >= 0; i--)
            if (!alarm_valid[i])
               slot = i;
         if (slot < 0) begin
            expected_words.push_back(done_word('0, STATUS_FULL));
         end else begin
            alarm_valid[slot] = 1'b1;
            alarm_ident[slot] = next_alarm_id;
            alarm_hour[slot] = r.hour;
            alarm_minute[slot] = r.minute;
            alarm_days[slot] = r.day_mask;
            alarm_enabled[slot] = r.enable;
            alarm_fired[slot] = 1'b0;
            expected_words.push_back(done_word(next_alarm_id, STATUS_OK));
            next_alarm_id = next_alarm_id + ID_W'(1);
         end
      end else if (r.op == OP_REMOVE || r.op == OP_UPDATE || r.op == OP_ENABLE) begin
         for (int i = SLOTS - 1; i >= 0; i--)
            if (alarm_valid[i] && alarm_ident[i] == r.alarm_id)
               slot = i;
         if (slot < 0) begin
            expected_words.push_back(done_word(r.alarm_id, STATUS_NOT_FOUND));
         end else begin
            if (r.op == OP_REMOVE) begin
               for (int i = slot; i + 1 < SLOTS; i++) begin
                  alarm_valid[i] = alarm_valid[i + 1];
                  alarm_ident[i] = alarm_ident[i + 1];
                  alarm_hour[i] = alarm_hour[i + 1];
                  alarm_minute[i] = alarm_minute[i + 1];
                  alarm_days[i] = alarm_days[i + 1];
                  alarm_enabled[i] = alarm_enabled[i + 1];
                  alarm_fired[i] = alarm_fired[i + 1];
               end
               alarm_valid[SLOTS - 1] = 1'b0;
               alarm_fired[SLOTS - 1] = 1'b0;
            end else if (r.op == OP_UPDATE) begin
               alarm_hour[slot] = r.hour;
               alarm_minute[slot] = r.minute;
               alarm_days[slot] = r.day_mask;
               alarm_enabled[slot] = r.enable;
               alarm_fired[slot] = 1'b0;
            end else begin
               alarm_enabled[slot] = r.enable;
            end
            expected_words.push_back(done_word(r.alarm_id, STATUS_OK));
         end
      end
   endfunction

   function automatic void check_field(string name, logic [ID_W-1:0] want,
                                       logic [ID_W-1:0] got);
      if (got !== want) begin
         $error("%s: expected %0d, got %0d", name, want, got);
         mismatch_count++;
      end
   endfunction

   always @(posedge clock) begin : rsp_check
      alarm_result_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_words.size() == 0) begin
            $error("unexpected result word: kind %0d, id %0d, status %0d",
                   rsp_kind, rsp_result_id, rsp_status);
            mismatch_count++;
         end else begin
            want = expected_words.pop_front();
            check_field("kind", ID_W'(want.kind), ID_W'(rsp_kind));
            check_field("result_id", want.result_id, rsp_result_id);
            check_field("status", ID_W'(want.status), ID_W'(rsp_status));
            check_field("last", ID_W'(want.last), ID_W'(rsp_last));
            words_checked++;
            if (want.kind == KIND_FIRED)
               fired_words++;
            if (want.status == STATUS_FULL)
               full_replies++;
            if (want.status == STATUS_NOT_FOUND)
               missing_replies++;
         end
      end
   end

   always @(posedge clock) begin
      if (rsp_valid && !rsp_stall)
         rsp_gap_left = $urandom_range(0, receiver_idle_max);
      if (rsp_hold_left > 0) begin
         rsp_hold_left--;
         rsp_stall <= 1'b1;
      end else if (rsp_gap_left > 0) begin
         rsp_gap_left--;
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= 1'b0;
      end
   end

   function automatic alarm_request_type make_request(logic [OP_W-1:0] op,
                                                      logic [ID_W-1:0] ident,
                                                      logic [HOUR_W-1:0] hour,
                                                      logic [MIN_W-1:0] minute,
                                                      logic [DAYS_W-1:0] mask,
                                                      logic enable,
                                                      logic [DOW_W-1:0] dow);
      alarm_request_type r;
      r.op = op;
      r.alarm_id = ident;
      r.hour = hour;
      r.minute = minute;
      r.day_mask = mask;
      r.enable = enable;
      r.day_of_week = dow;
      return r;
   endfunction

   task automatic send_request(input alarm_request_type r);
      int unsigned gap;
      gap = $urandom_range(0, sender_idle_max);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_op <= r.op;
      req_alarm_id <= r.alarm_id;
      req_hour <= r.hour;
      req_minute <= r.minute;
      req_day_mask <= r.day_mask;
      req_enable <= r.enable;
      req_day_of_week <= r.day_of_week;
      @(posedge clock);
      while (req_stall)
         @(posedge clock);
      predict_alarm_words(r);
      requests_sent++;
   endtask

   task automatic send_tick(input logic [HOUR_W-1:0] hour, input logic [MIN_W-1:0] minute,
                            input logic [DOW_W-1:0] dow);
      send_request(make_request(OP_TICK, ID_W'($urandom), hour, minute,
                                DAYS_W'($urandom), 1'($urandom), dow));
   endtask

   task automatic send_add(input logic [HOUR_W-1:0] hour, input logic [MIN_W-1:0] minute,
                           input logic [DAYS_W-1:0] mask, input logic enable);
      send_request(make_request(OP_ADD, ID_W'($urandom), hour, minute, mask, enable,
                                DOW_W'($urandom)));
   endtask

   task automatic send_lookup(input logic [OP_W-1:0] op, input logic [ID_W-1:0] ident,
                              input logic [HOUR_W-1:0] hour, input logic [MIN_W-1:0] minute,
                              input logic [DAYS_W-1:0] mask, input logic enable);
      send_request(make_request(op, ident, hour, minute, mask, enable, DOW_W'($urandom)));
   endtask

   // Sends a lookup whose alarm fields are don't-cares, except for the enable flag.
   task automatic send_lookup_any(input logic [OP_W-1:0] op, input logic [ID_W-1:0] ident,
                                  input logic enable);
      send_lookup(op, ident, HOUR_W'($urandom), MIN_W'($urandom), DAYS_W'($urandom),
                  enable);
   endtask

   task automatic set_idling(input int unsigned cycles);
      sender_idle_max = cycles;
      receiver_idle_max = cycles;
   endtask

   task automatic wait_for_results();
      int waited;
      waited = 0;
      req_valid <= 1'b0;
      while (expected_words.size() != 0 && waited < DRAIN_LIMIT) begin
         @(posedge clock);
         waited++;
      end
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (expected_words.size() != 0) begin
         $error("%0d expected result words never arrived", expected_words.size());
         mismatch_count++;
      end
   endtask

   task automatic test_table_fill(output logic [ID_W-1:0] first_id);
      set_idling(5);
      first_id = next_alarm_id;
      send_add(0, 0, '0, 1'b1);
      send_add(23, 59, 7'h7F, 1'b1);
      send_add(23, 59, 7'h40, 1'b1);
      send_add(23, 59, 7'h01, 1'b0);
      send_add(31, 63, '0, 1'b1);
      send_add(12, 30, 7'h3E, 1'b1);
      while (table_count() < SLOTS)
         send_add(12, 30, (table_count() % 2 != 0) ? 7'h7F : 7'h00, 1'b1);
      send_add(1, 1, 7'h55, 1'b1);
   endtask

   task automatic test_tick_matching();
      send_tick(23, 59, 6);
      send_tick(23, 59, 6);
      send_tick(0, 0, 7);
      send_tick(0, 0, 0);
      send_tick(12, 30, 0);
      send_tick(31, 63, 2);
   endtask

   task automatic test_lookups(input logic [ID_W-1:0] first_id);
      send_lookup(OP_UPDATE, first_id + ID_W'(5), 12, 30, '0, 1'b1);
      send_lookup_any(OP_ENABLE, first_id + ID_W'(3), 1'b1);
      send_lookup_any(OP_REMOVE, first_id + ID_W'(1), 1'($urandom));
      send_lookup_any(OP_REMOVE, 16'hFFFF, 1'($urandom));
      send_lookup_any(OP_ENABLE, 16'h8000, 1'b0);
      send_lookup(OP_UPDATE, 16'h5555, 17, 42, 7'h2A, 1'b1);
      send_tick(12, 30, 0);
   endtask

   task automatic test_reserved_ops();
      for (logic [OP_W:0] op = (OP_W + 1)'(OP_RESERVED); op <= (OP_W + 1)'(OP_TOP); op++)
         send_request(make_request(op[OP_W-1:0], ID_W'($urandom), HOUR_W'($urandom),
                                   MIN_W'($urandom), DAYS_W'($urandom), 1'($urandom),
                                   DOW_W'($urandom)));
   endtask

   // The receiver holds off while requests keep coming, so the output fills and
   // the block has to stall its input.
   task automatic test_output_backpressure(input logic [ID_W-1:0] first_id);
      set_idling(0);
      rsp_hold_left = 300;
      send_tick(0, 0, 3);
      send_tick(12, 30, 3);
      send_tick(23, 59, 6);
      send_add(8, 8, 7'h7F, 1'b1);
      send_lookup_any(OP_REMOVE, first_id + ID_W'(2), 1'($urandom));
      send_add(23, 59, '0, 1'b1);
      send_tick(23, 59, 6);
      send_tick(12, 30, 5);
      wait_for_results();
   endtask

   task automatic test_random_traffic(input int items);
      alarm_request_type r;
      int done_items;
      int pick;
      int slot;
      int count;
      done_items = 0;
      while (done_items < items) begin
         if (done_items % 100 == 0)
            set_idling(((done_items / 100) % 3 == 1) ? 0 : 5);
         r.alarm_id = ID_W'($urandom);
         r.day_mask = ($urandom_range(0, 3) == 0) ? '0 : DAYS_W'($urandom_range(1, 7'h7F));
         r.enable = ($urandom_range(0, 4) != 0);
         r.day_of_week = DOW_W'($urandom_range(0, DOW_TOP));
         pick = int'($urandom_range(0, 99));
         if (pick < 70) begin
            case ($urandom_range(0, 3))
               0: begin r.hour = 0; r.minute = 0; end
               1: begin r.hour = 7; r.minute = 30; end
               2: begin r.hour = 12; r.minute = 15; end
               default: begin r.hour = 23; r.minute = 59; end
            endcase
         end else if (pick < 85) begin
            r.hour = HOUR_W'($urandom_range(0, 31));
            r.minute = MIN_W'($urandom_range(0, 63));
         end else begin
            r.hour = HOUR_W'($urandom_range(0, 23));
            r.minute = MIN_W'($urandom_range(0, 59));
         end
         count = table_count();
         slot = (count > 0) ? int'($urandom_range(0, count - 1)) : -1;
         pick = int'($urandom_range(0, 99));
         if (pick < 40) begin
            r.op = OP_TICK;
            if (slot >= 0 && $urandom_range(0, 99) < 60) begin
               r.hour = alarm_hour[slot];
               r.minute = alarm_minute[slot];
            end
         end else if (pick < 60) begin
            r.op = OP_ADD;
         end else if (pick < 96) begin
            r.op = (pick < 74) ? OP_REMOVE : (pick < 85) ? OP_UPDATE : OP_ENABLE;
            if (slot >= 0 && $urandom_range(0, 99) < 80)
               r.alarm_id = alarm_ident[slot];
         end else begin
            r.op = OP_W'($urandom_range(OP_RESERVED, OP_TOP));
         end
         send_request(r);
         if (r.op < OP_RESERVED)
            done_items++;
      end
   endtask

   initial begin
      logic [ID_W-1:0] first_id;
      clear_alarm_table();
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_table_fill(first_id);
      test_tick_matching();
      test_lookups(first_id);
      test_reserved_ops();
      test_output_backpressure(first_id);
      test_random_traffic(RANDOM_ITEMS);
      wait_for_results();
      $display("Sent %0d requests, including a full table, unused ops and a held output.",
               requests_sent);
      $display("Checked %0d words: %0d alarm firings, %0d full-table and %0d missing-id replies.",
               words_checked, fired_words, full_replies, missing_replies);
      if (mismatch_count == 0)
         $display("PASS");
      else
         $display("FAIL");
      $finish;
   end

endmodule
